// ===== rtl/ids_pkg.sv =====
// Shared types and constants for the indexed deque store.
// Used by ids_ctrl, ids_dpath, the top level and the checker; depends on nothing.
`default_nettype none
package ids_pkg;

   localparam int DATA_W        = 32;
   localparam int ACTION_W      = 3;
   localparam int POS_W         = 4;
   localparam int COUNT_OUT_W   = 5;
   localparam int DEPTH_DEFAULT = 16;

   // Request beat: action, value, position packed from bit 0, padded to bytes.
   localparam int REQ_BITS  = ACTION_W + DATA_W + POS_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   // Response beat: removed value, status, count packed from bit 0.
   localparam int RSP_BITS  = DATA_W + 2 + COUNT_OUT_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_INS_BACK  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_INS_AT    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_REM_FRONT = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_REM_BACK  = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_REM_AT    = 3'd5;

   localparam logic signed [DATA_W-1:0] ERR_VALUE = -32'sd1;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BOUNDS = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the accepted request beat
      logic commit;  // apply the action and fill the response register
   } cmd_type;

endpackage
`default_nettype wire

// ===== rtl/ids_ctrl.sv =====
// Controller for the indexed deque store: request/response handshake sequencing.
// Depends on ids_pkg for the state and command types.
`default_nettype none
module ids_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   output ids_pkg::cmd_type     cmd
);

   ids_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ids_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ids_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ids_pkg::S_EXEC;
            end
         end
         ids_pkg::S_EXEC: begin
            // The response register must be free or draining this cycle.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in   = ids_pkg::S_IDLE;
            end
         end
         default: state_in = ids_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/ids_dpath.sv =====
// Datapath for the indexed deque store: request register, shifting cell chain,
// element count and response register. Depends on ids_pkg.
`default_nettype none
module ids_dpath #(
   parameter int DEPTH = ids_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire ids_pkg::cmd_type                       cmd,
   input  wire logic [ids_pkg::ACTION_W-1:0]           req_action,
   input  wire logic signed [ids_pkg::DATA_W-1:0]      req_value,
   input  wire logic [ids_pkg::POS_W-1:0]              req_position,
   output logic signed [ids_pkg::DATA_W-1:0]           rsp_removed_value,
   output logic [1:0]                                  rsp_status,
   output logic [ids_pkg::COUNT_OUT_W-1:0]             rsp_count
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > ids_pkg::POS_W) ? CNT_W : ids_pkg::POS_W;

   logic [ids_pkg::ACTION_W-1:0]      action_ff;
   logic signed [ids_pkg::DATA_W-1:0] value_ff;
   logic [ids_pkg::POS_W-1:0]         pos_ff;

   logic signed [ids_pkg::DATA_W-1:0] cell_ff [DEPTH];
   logic signed [ids_pkg::DATA_W-1:0] cell_in [DEPTH];
   logic [CNT_W-1:0]                  count_ff, count_in;

   logic signed [ids_pkg::DATA_W-1:0] removed_ff, removed_in;
   ids_pkg::status_type               status_ff, status_in;
   logic [ids_pkg::COUNT_OUT_W-1:0]   count_out_ff;

   logic             do_ins, do_rem, full, empty, pos_bad;
   logic [IDX_W-1:0] slot;

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         value_ff  <= req_value;
         pos_ff    <= req_position;
      end
   end

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pos_bad = (CMP_W'(pos_ff) >= CMP_W'(count_ff));

   // Decode the action into a shift direction and a slot.
   always_comb begin
      do_ins     = 1'b0;
      do_rem     = 1'b0;
      slot       = '0;
      status_in  = ids_pkg::ST_OK;
      removed_in = '0;
      case (action_ff)
         ids_pkg::ACT_INS_FRONT, ids_pkg::ACT_INS_BACK, ids_pkg::ACT_INS_AT: begin
            if (full) begin
               status_in = ids_pkg::ST_FULL;
            end else if (action_ff == ids_pkg::ACT_INS_BACK) begin
               do_ins = 1'b1;
               slot   = IDX_W'(count_ff);
            end else if (action_ff == ids_pkg::ACT_INS_FRONT || empty) begin
               do_ins = 1'b1;
            end else if (pos_bad) begin
               status_in = ids_pkg::ST_BOUNDS;
            end else begin
               do_ins = 1'b1;
               slot   = IDX_W'(pos_ff);
            end
         end
         ids_pkg::ACT_REM_FRONT, ids_pkg::ACT_REM_BACK, ids_pkg::ACT_REM_AT: begin
            if (empty) begin
               status_in  = ids_pkg::ST_EMPTY;
               removed_in = ids_pkg::ERR_VALUE;
            end else if (action_ff == ids_pkg::ACT_REM_FRONT) begin
               do_rem = 1'b1;
            end else if (action_ff == ids_pkg::ACT_REM_BACK) begin
               do_rem = 1'b1;
               slot   = IDX_W'(count_ff - CNT_W'(1));
            end else if (pos_bad) begin
               status_in  = ids_pkg::ST_BOUNDS;
               removed_in = ids_pkg::ERR_VALUE;
            end else begin
               do_rem = 1'b1;
               slot   = IDX_W'(pos_ff);
            end
            if (do_rem) begin
               removed_in = cell_ff[slot];
            end
         end
         default: begin
            status_in = ids_pkg::ST_OK;
         end
      endcase
   end

   // Each cell looks only at its neighbors: shift toward the back on insert,
   // toward the front on removal, and hold below the slot.
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         cell_in[k] = cell_ff[k];
         if (do_ins) begin
            if (IDX_W'(k) == slot) begin
               cell_in[k] = value_ff;
            end else if (k > 0 && IDX_W'(k) > slot) begin
               cell_in[k] = cell_ff[(k > 0) ? k - 1 : 0];
            end
         end else if (do_rem) begin
            if (k < DEPTH - 1 && IDX_W'(k) >= slot) begin
               cell_in[k] = cell_ff[(k < DEPTH - 1) ? k + 1 : k];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rem) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         cell_ff <= cell_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         removed_ff   <= removed_in;
         status_ff    <= status_in;
         count_out_ff <= ids_pkg::COUNT_OUT_W'(count_in);
      end
   end

   assign rsp_removed_value = removed_ff;
   assign rsp_status        = status_ff;
   assign rsp_count         = count_out_ff;

endmodule
`default_nettype wire

// ===== rtl/indexed_deque_store.sv =====
// Top level of the indexed deque store: stream ports, controller and datapath.
// Depends on ids_pkg, ids_ctrl and ids_dpath.
//
// Usage:
// The block holds an ordered list of up to DEPTH signed 32-bit values. Each
// beat on the request channel (req_) carries one action: insert at the front,
// at the back or before a position, or remove from the front, the back or a
// position. Every request beat yields exactly one response beat (rsp_) with
// the removed value, a status code and the element count after the action.
// Errors (empty list, bad position, full list) leave the list untouched.
// A request is captured in the request register when it is accepted and is
// applied to the chain of shifting cells, whose elements all move in parallel,
// once the response register is free or draining; its response is valid from
// the edge that applies it. No new request is accepted before that edge.
// The response sits in an output register, so the next request is accepted
// while the previous response still waits. If the receiver keeps rsp_tready
// low, the following action waits in the apply state and req_tready stays low
// until the response register is free.
// Reset (synchronous, active high) empties the list and drops any pending
// response. Cell contents are not cleared; a cell is only read after it has
// been written.
`default_nettype none
module indexed_deque_store #(
   parameter int DEPTH = ids_pkg::DEPTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // req_tdata, from bit 0: action[2:0], value[34:3], position[38:35], zero pad.
   input  wire logic [ids_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // rsp_tdata, from bit 0: removed_value[31:0], status[33:32], count[38:34],
   // zero pad.
   output logic [ids_pkg::RSP_TDATA_W-1:0]         rsp_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready
);

   localparam int VAL_LO = ids_pkg::ACTION_W;
   localparam int POS_LO = VAL_LO + ids_pkg::DATA_W;

   ids_pkg::cmd_type                   cmd;
   logic signed [ids_pkg::DATA_W-1:0]  removed_value;
   logic [1:0]                         status;
   logic [ids_pkg::COUNT_OUT_W-1:0]    count;

   ids_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ids_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_action        (req_tdata[ids_pkg::ACTION_W-1:0]),
      .req_value         (req_tdata[POS_LO-1:VAL_LO]),
      .req_position      (req_tdata[POS_LO+ids_pkg::POS_W-1:POS_LO]),
      .rsp_removed_value (removed_value),
      .rsp_status        (status),
      .rsp_count         (count)
   );

   assign rsp_tdata = ids_pkg::RSP_TDATA_W'({count, status, removed_value});

endmodule
`default_nettype wire

// ===== rtl/ids_checker.sv =====
// Port-level checker for the indexed deque store, bound to the top level.
// Depends on ids_pkg and sees only the top level's ports.
`default_nettype none
module ids_checker #(
   parameter int DEPTH = ids_pkg::DEPTH_DEFAULT
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [ids_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready
);

   localparam int ST_LO  = ids_pkg::DATA_W;
   localparam int CNT_LO = ST_LO + 2;

   logic [1:0]                      rsp_status;
   logic [ids_pkg::DATA_W-1:0]      rsp_removed;
   logic [ids_pkg::COUNT_OUT_W-1:0] rsp_count;

   assign rsp_removed = rsp_tdata[ids_pkg::DATA_W-1:0];
   assign rsp_status  = rsp_tdata[CNT_LO-1:ST_LO];
   assign rsp_count   = rsp_tdata[CNT_LO+ids_pkg::COUNT_OUT_W-1:CNT_LO];

   // A stalled response keeps its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response dropped or changed");

   // One action at a time: right after an accepted request the port is closed.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while an action was in flight");

   // An empty-list removal reports -1 and an empty list.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == ids_pkg::ST_EMPTY |->
         rsp_removed == ids_pkg::ERR_VALUE && rsp_count == '0)
      else $error("empty status with wrong value or count");

   // A full-list insert removes nothing and reports a full count.
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == ids_pkg::ST_FULL |->
         rsp_removed == '0 && rsp_count == ids_pkg::COUNT_OUT_W'(DEPTH))
      else $error("full status with wrong value or count");

   // A bad position either inserts nothing (value 0) or removes nothing (-1).
   a_bounds_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == ids_pkg::ST_BOUNDS |->
         rsp_removed == '0 || rsp_removed == ids_pkg::ERR_VALUE)
      else $error("out-of-bounds status with a taken value");

endmodule

bind indexed_deque_store ids_checker #(.DEPTH(DEPTH)) u_ids_checker (.*);
`default_nettype wire

// ===== tb/sv/indexed_deque_store_test.sv =====
// Self-checking testbench for indexed_deque_store: drives request beats, predicts each
// response with its own list model and compares every response field by field.
// Depends on ids_pkg and the indexed_deque_store RTL.
`timescale 1ns / 1ps

module indexed_deque_store_test;

   // The two action codes that the block must treat as no-ops.
   localparam logic [ids_pkg::ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ids_pkg::ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

   localparam int LIST_DEPTH     = ids_pkg::DEPTH_DEFAULT;
   localparam int HOLD_CYCLES    = 300;   // long receiver hold-off in the backpressure test
   localparam int WATCHDOG_LIMIT = 3000;  // quiet cycles allowed before giving up
   localparam int DRAIN_CYCLES   = 8;     // settle time after the last response
   localparam int RANDOM_BEATS   = 150;   // per random traffic pass; two passes are run
   localparam int MAX_REPORTS    = 100;   // printed error lines are capped, all are counted

   // One predicted response beat.
   typedef struct packed {
      logic [ids_pkg::DATA_W-1:0]      removed;
      ids_pkg::status_type             status;
      logic [ids_pkg::COUNT_OUT_W-1:0] count;
   } deque_result_type;

   logic                            clock;
   logic                            reset      = 1'b1;
   logic [ids_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [ids_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;

   indexed_deque_store #(
      .DEPTH(LIST_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // The list as the testbench believes it to be, updated when a request beat is accepted.
   logic [ids_pkg::DATA_W-1:0] model_cells [LIST_DEPTH];
   int                         model_held = 0;

   // Responses that have been predicted but not yet seen, oldest first.
   deque_result_type  expected_responses [$];

   int  error_count         = 0;
   int  beats_sent          = 0;
   int  beats_checked       = 0;
   int  full_list_hits      = 0;
   int  input_stall_cycles  = 0;
   int  status_tally [4]    = '{0, 0, 0, 0};
   int  burst_left          = 0;
   bit  hold_request        = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Prints one line per problem, up to a cap, and counts all of them.
   task automatic report_error(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("[%0t] error: %s", $realtime, what);
      end
   endtask

   // Applies one action to the model list and returns the response the block should give.
   // Errors leave the list untouched; a full list is checked before any position.
   function automatic deque_result_type predict_deque_action(
      input logic [ids_pkg::ACTION_W-1:0] act,
      input logic [ids_pkg::DATA_W-1:0]   val,
      input logic [ids_pkg::POS_W-1:0]    pos
   );
      deque_result_type r;
      int               slot;
      int               k;
      r.removed = '0;
      r.status  = ids_pkg::ST_OK;
      slot      = -1;
      case (act)
         ids_pkg::ACT_INS_FRONT, ids_pkg::ACT_INS_BACK, ids_pkg::ACT_INS_AT: begin
            if (model_held >= LIST_DEPTH) begin
               r.status = ids_pkg::ST_FULL;
            end else if (act == ids_pkg::ACT_INS_FRONT || model_held == 0) begin
               // An indexed insert into an empty list lands at the front whatever the position.
               slot = 0;
            end else if (act == ids_pkg::ACT_INS_BACK) begin
               slot = model_held;
            end else if (int'(pos) >= model_held) begin
               r.status = ids_pkg::ST_BOUNDS;
            end else begin
               slot = int'(pos);
            end
            if (slot >= 0) begin
               for (k = model_held; k > slot; k--) begin
                  model_cells[k] = model_cells[k-1];
               end
               model_cells[slot] = val;
               model_held++;
            end
         end
         ids_pkg::ACT_REM_FRONT, ids_pkg::ACT_REM_BACK, ids_pkg::ACT_REM_AT: begin
            // Emptiness is checked before the position.
            if (model_held == 0) begin
               r.removed = ids_pkg::ERR_VALUE;
               r.status  = ids_pkg::ST_EMPTY;
            end else if (act == ids_pkg::ACT_REM_AT && int'(pos) >= model_held) begin
               r.removed = ids_pkg::ERR_VALUE;
               r.status  = ids_pkg::ST_BOUNDS;
            end else begin
               if (act == ids_pkg::ACT_REM_FRONT) begin
                  slot = 0;
               end else if (act == ids_pkg::ACT_REM_BACK) begin
                  slot = model_held - 1;
               end else begin
                  slot = int'(pos);
               end
               r.removed = model_cells[slot];
               for (k = slot; k + 1 < model_held; k++) begin
                  model_cells[k] = model_cells[k+1];
               end
               model_held--;
            end
         end
         default: begin
            // Spare action codes change nothing and report ok.
         end
      endcase
      r.count = ids_pkg::COUNT_OUT_W'(model_held);
      return r;
   endfunction

   // Offers one request beat and holds it until the block takes it. The prediction is made
   // at the accepting edge, so the model always tracks the block in acceptance order.
   // The sender works in bursts; between bursts valid drops for a random gap.
   task automatic offer_request(
      input logic [ids_pkg::ACTION_W-1:0] act,
      input logic [ids_pkg::DATA_W-1:0]   val,
      input logic [ids_pkg::POS_W-1:0]    pos
   );
      logic [ids_pkg::REQ_TDATA_W-1:0] beat;
      deque_result_type                want;
      int                              gap;
      beat = '0;
      beat[0 +: ids_pkg::ACTION_W]                               = act;
      beat[ids_pkg::ACTION_W +: ids_pkg::DATA_W]                 = val;
      beat[ids_pkg::ACTION_W + ids_pkg::DATA_W +: ids_pkg::POS_W] = pos;
      req_tdata  <= beat;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      want = predict_deque_action(act, val, pos);
      expected_responses.push_back(want);
      status_tally[int'(want.status)]++;
      if (want.count == ids_pkg::COUNT_OUT_W'(LIST_DEPTH)) begin
         full_list_hits++;
      end
      beats_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         // Mostly short bursts, now and then a long unbroken run.
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic logic [ids_pkg::ACTION_W-1:0] random_insert_action();
      case ($urandom_range(0, 2))
         0:       return ids_pkg::ACT_INS_FRONT;
         1:       return ids_pkg::ACT_INS_BACK;
         default: return ids_pkg::ACT_INS_AT;
      endcase
   endfunction

   function automatic logic [ids_pkg::ACTION_W-1:0] random_remove_action();
      case ($urandom_range(0, 2))
         0:       return ids_pkg::ACT_REM_FRONT;
         1:       return ids_pkg::ACT_REM_BACK;
         default: return ids_pkg::ACT_REM_AT;
      endcase
   endfunction

   // Mostly a position that exists in the current list, sometimes any position at all.
   function automatic logic [ids_pkg::POS_W-1:0] random_position();
      if (model_held > 0 && $urandom_range(0, 9) < 8) begin
         return ids_pkg::POS_W'($urandom_range(0, model_held - 1));
      end
      return ids_pkg::POS_W'($urandom_range(0, LIST_DEPTH - 1));
   endfunction

   // Mostly fully random values, with the signed extremes, zero and minus one mixed in.
   function automatic logic [ids_pkg::DATA_W-1:0] random_element();
      case ($urandom_range(0, 15))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Every removal on an empty list, plus the spare codes with nonzero fields.
   task automatic check_empty_list_errors();
      offer_request(ids_pkg::ACT_REM_FRONT, 32'h0000_0007, 4'd0);
      offer_request(ids_pkg::ACT_REM_BACK,  32'hFFFF_FFF9, 4'd15);
      offer_request(ids_pkg::ACT_REM_AT,    32'h0000_0000, 4'd15);
      offer_request(ids_pkg::ACT_REM_AT,    32'h0000_0000, 4'd0);
      offer_request(ACT_SPARE_6,            32'h1234_5678, 4'd3);
      offer_request(ACT_SPARE_7,            32'hFFFF_FFFF, 4'd15);
   endtask

   // Indexed inserts and removals at the edges of a short list, with extreme values.
   task automatic check_edge_inserts();
      // Empty list: the value becomes the only element.
      offer_request(ids_pkg::ACT_INS_AT,    32'h7FFF_FFFF, 4'd15);
      offer_request(ids_pkg::ACT_INS_FRONT, 32'h8000_0000, 4'd0);
      offer_request(ids_pkg::ACT_INS_BACK,  32'h0000_0000, 4'd9);
      offer_request(ids_pkg::ACT_INS_AT,    32'hFFFF_FFFF, 4'd1);
      // Position equal to the count is rejected.
      offer_request(ids_pkg::ACT_INS_AT,    32'h0BAD_0BAD, 4'd4);
      // Indexed insert that moves the head.
      offer_request(ids_pkg::ACT_INS_AT,    32'h5A5A_A5A5, 4'd0);
      // Just before the last element.
      offer_request(ids_pkg::ACT_INS_AT,    32'h0000_0001, 4'd4);
      offer_request(ids_pkg::ACT_REM_AT,    32'h0000_0000, 4'd15);
      offer_request(ids_pkg::ACT_REM_AT,    32'h0000_0000, 4'd6);   // position equal to count
      offer_request(ids_pkg::ACT_REM_AT,    32'h0000_0000, 4'd5);   // last element
      offer_request(ids_pkg::ACT_REM_AT,    32'h0000_0000, 4'd0);
      offer_request(ids_pkg::ACT_REM_AT,    32'h0000_0000, 4'd2);
      offer_request(ids_pkg::ACT_REM_BACK,  32'h0000_0000, 4'd0);
      offer_request(ids_pkg::ACT_REM_FRONT, 32'h0000_0000, 4'd0);
      offer_request(ACT_SPARE_6,            32'hFFFF_FFFF, 4'd0);   // count must stay put
      offer_request(ids_pkg::ACT_REM_AT,    32'h0000_0000, 4'd0);   // the only element left
      offer_request(ids_pkg::ACT_REM_BACK,  32'h0000_0000, 4'd0);
   endtask

   // Fills the list to capacity, hits it with every insert, then drains it completely.
   task automatic check_full_list();
      while (model_held < LIST_DEPTH) begin
         offer_request(random_insert_action(), random_element(), random_position());
      end
      offer_request(ids_pkg::ACT_INS_FRONT, random_element(), 4'd0);
      offer_request(ids_pkg::ACT_INS_BACK,  random_element(), 4'd15);
      offer_request(ids_pkg::ACT_INS_AT,    random_element(), 4'd15);
      offer_request(ids_pkg::ACT_INS_AT,    random_element(), 4'd0);
      offer_request(ids_pkg::ACT_REM_AT,    random_element(), 4'd15);  // last slot when full
      offer_request(ids_pkg::ACT_INS_AT,    random_element(), 4'd15);  // now one past the end
      offer_request(ids_pkg::ACT_INS_BACK,  random_element(), 4'd0);
      offer_request(ids_pkg::ACT_REM_AT,    random_element(), 4'd7);
      while (model_held > 0) begin
         offer_request(random_remove_action(), random_element(), random_position());
      end
      offer_request(ids_pkg::ACT_REM_AT, random_element(), random_position());
   endtask

   // Random traffic in tides: a filling tide favors inserts, a draining tide removals, so the
   // list keeps swinging between empty and full. Spare codes are sprinkled in but not counted.
   task automatic run_random_traffic(input int beats);
      int                           sent;
      int                           tide_left;
      bit                           filling;
      int                           roll;
      logic [ids_pkg::ACTION_W-1:0] act;
      sent      = 0;
      tide_left = 0;
      filling   = 1'b0;
      while (sent < beats) begin
         if (tide_left == 0) begin
            tide_left = $urandom_range(10, 50);
            filling   = !filling;
         end
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            act = roll[0] ? ACT_SPARE_7 : ACT_SPARE_6;
         end else if ((roll < 74) == filling) begin
            act = random_insert_action();
         end else begin
            act = random_remove_action();
         end
         offer_request(act, random_element(), random_position());
         if (act != ACT_SPARE_6 && act != ACT_SPARE_7) begin
            sent++;
         end
         tide_left--;
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering, so the
   // response register and the apply stage fill and the block must stall its input.
   task automatic check_backpressure();
      hold_request = 1'b1;
      run_random_traffic(24);
      while (hold_request) begin
         @(posedge clock);
      end
   endtask

   // Receiver: switches between four randomly drawn stall patterns, one of which never stalls.
   // A hold request from the backpressure test takes priority and is timed here.
   initial begin : response_drain
      int phase;
      int stall_mode;
      int held_cycles;
      phase      = 0;
      stall_mode = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            for (held_cycles = 0; held_cycles < HOLD_CYCLES; held_cycles++) begin
               @(posedge clock);
            end
            hold_request = 1'b0;
         end else begin
            if (phase % 40 == 0) begin
               stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 3) != 0);
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (phase % 3 != 0);
            endcase
            phase++;
         end
      end
   end

   // Response checker: every accepted response beat is matched with the oldest prediction.
   always @(posedge clock) begin : response_check
      deque_result_type                want;
      logic [ids_pkg::DATA_W-1:0]      got_value;
      logic [1:0]                      got_status;
      logic [ids_pkg::COUNT_OUT_W-1:0] got_count;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_value  = rsp_tdata[0 +: ids_pkg::DATA_W];
         got_status = rsp_tdata[ids_pkg::DATA_W +: 2];
         got_count  = rsp_tdata[ids_pkg::DATA_W + 2 +: ids_pkg::COUNT_OUT_W];
         if (expected_responses.size() == 0) begin
            report_error($sformatf("response beat with nothing outstanding: value %h status %0d",
                                   got_value, got_status));
         end else begin
            want = expected_responses.pop_front();
            if (got_value !== want.removed) begin
               report_error($sformatf("beat %0d removed_value %h, expected %h",
                                      beats_checked, got_value, want.removed));
            end
            if (got_status !== want.status) begin
               report_error($sformatf("beat %0d status %0d, expected %0d",
                                      beats_checked, got_status, want.status));
            end
            if (got_count !== want.count) begin
               report_error($sformatf("beat %0d count %0d, expected %0d",
                                      beats_checked, got_count, want.count));
            end
         end
         beats_checked++;
      end
   end

   // Watchdog: any accepted beat on either side counts as progress.
   always @(posedge clock) begin : progress_watch
      int quiet_cycles;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] error: no beat accepted for %0d cycles, %0d responses outstanding",
                     $realtime, WATCHDOG_LIMIT, expected_responses.size());
            $display("indexed_deque_store: mismatch");
            $finish;
         end
      end
   end

   // Counts cycles in which the block refuses an offered request.
   always @(posedge clock) begin
      if (!reset && req_tvalid && !req_tready) begin
         input_stall_cycles++;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      check_empty_list_errors();
      check_edge_inserts();
      check_full_list();
      run_random_traffic(RANDOM_BEATS);
      check_backpressure();
      run_random_traffic(RANDOM_BEATS);

      // Stop offering, let every outstanding response arrive, then keep watching through the
      // settle time for anything unexpected.
      req_tvalid <= 1'b0;
      while (expected_responses.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d request beats: %0d ok, %0d empty, %0d out of bounds, %0d full.",
               beats_sent, status_tally[ids_pkg::ST_OK], status_tally[ids_pkg::ST_EMPTY],
               status_tally[ids_pkg::ST_BOUNDS], status_tally[ids_pkg::ST_FULL]);
      $display("List reached capacity %0d times; the input was held off for %0d cycles.",
               full_list_hits, input_stall_cycles);
      if (error_count == 0) begin
         $display("indexed_deque_store: match");
      end else begin
         $display("indexed_deque_store: mismatch");
      end
      $finish;
   end

endmodule
